// ===== rtl/dsr_pkg.sv =====
// Shared codes, defaults and types for the depth sorted slot registry.
`default_nettype none
package dsr_pkg;

  localparam int SLOTS_DEF        = 32;
  localparam int KEY_BITS_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam logic [2:0] OP_SUBMIT  = 3'd0;
  localparam logic [2:0] OP_UPDATE  = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_FLUSH   = 3'd3;
  localparam logic [2:0] OP_CLRFLAG = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;
  localparam logic [1:0] ST_NOTHING  = 2'd3;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/dsr_cell.sv =====
// One insertion sorter cell: holds one entry, passes the larger key to its neighbor.
`default_nettype none
module dsr_cell #(
  parameter int KEY_BITS = 16,
  parameter int SW       = 5
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  dsr_pkg::cell_ctl_t         ctl,
  input  wire                        ins_v,
  input  wire logic signed [KEY_BITS-1:0] ins_key,
  input  wire        [SW-1:0]        ins_slot,
  input  wire                        nb_occ,
  input  wire logic signed [KEY_BITS-1:0] nb_key,
  input  wire        [SW-1:0]        nb_slot,
  output logic                       occ,
  output logic signed [KEY_BITS-1:0] key,
  output logic       [SW-1:0]        slot,
  output logic                       pass_v,
  output logic signed [KEY_BITS-1:0] pass_key,
  output logic       [SW-1:0]        pass_slot
);
  import dsr_pkg::*;

  logic                       occ_r;
  logic signed [KEY_BITS-1:0] key_r;
  logic        [SW-1:0]       slot_r;
  logic                       pv_r;
  logic signed [KEY_BITS-1:0] pk_r;
  logic        [SW-1:0]       ps_r;

  // ties on key go by slot, so the chain ends up stable in slot order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      pv_r  <= 1'b0;
    end else if (ctl.clear) begin
      occ_r <= 1'b0;
      pv_r  <= 1'b0;
    end else if (ctl.shift) begin
      occ_r  <= nb_occ;
      key_r  <= nb_key;
      slot_r <= nb_slot;
      pv_r   <= 1'b0;
    end else if (ins_v) begin
      if (!occ_r) begin
        occ_r  <= 1'b1;
        key_r  <= ins_key;
        slot_r <= ins_slot;
        pv_r   <= 1'b0;
      end else if ((ins_key < key_r) || ((ins_key == key_r) && (ins_slot < slot_r))) begin
        key_r  <= ins_key;
        slot_r <= ins_slot;
        pv_r   <= 1'b1;
        pk_r   <= key_r;
        ps_r   <= slot_r;
      end else begin
        pv_r <= 1'b1;
        pk_r <= ins_key;
        ps_r <= ins_slot;
      end
    end else begin
      pv_r <= 1'b0;
    end
  end

  assign occ       = occ_r;
  assign key       = key_r;
  assign slot      = slot_r;
  assign pass_v    = pv_r;
  assign pass_key  = pk_r;
  assign pass_slot = ps_r;

endmodule
`default_nettype wire

// ===== rtl/depth_sorted_slot_registry_unit.sv =====
// Top level of the depth sorted slot registry: slot table, lists and sorter chain.
// Usage: one input channel (in_*) carries requests: submit, update, release,
// flush and clear-flag. One result channel (out_*) returns one result per
// request, or one result per emitted entry for a flush, the final one with
// out_last set. Both channels use valid/stall; an item moves when valid is high
// and stall low.
// Sequencing: a table request passes a memory lookup state, then an execute
// state that loads the output register, then idle, where the next request can
// be accepted. A dirty flush passes read states for the dirty list and then
// for the position and entry memories, then an emit state, for each emitted
// entry. A rebuild flush streams the live entries through a chain of SLOTS
// insertion cells and then drains the chain entry by entry (payload memory read, emit).
// One request is worked at a time; in_stall is high while it is in flight.
// The next request is accepted while the last result still sits in the output
// register. When the receiver stalls, the output register holds and the
// sequencer waits before producing the next result.
// Reset (rst_n, synchronous) clears live/dirty bits, counters and pending
// rebuild; the entry, list and position memories are not cleared.
`default_nettype none
module depth_sorted_slot_registry_unit #(
  parameter int SLOTS        = dsr_pkg::SLOTS_DEF,
  parameter int KEY_BITS     = dsr_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = dsr_pkg::PAYLOAD_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire        [2:0]   in_operation,
  input  wire        [4:0]   in_slot_id,
  input  wire logic signed [15:0] in_depth_key,
  input  wire        [63:0]  in_payload,
  output logic               out_valid,
  input  wire                out_stall,
  output logic       [1:0]   out_status,
  output logic       [4:0]   out_slot_out,
  output logic       [4:0]   out_position,
  output logic signed [15:0] out_key_out,
  output logic       [63:0]  out_payload_out,
  output logic               out_full_refresh,
  output logic               out_entry_valid,
  output logic               out_last
);
  import dsr_pkg::*;

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int CW   = $clog2(2 * SLOTS + 3);
  localparam int EW   = KEY_BITS + PAYLOAD_BITS;
  localparam logic [CW-1:0] LOAD_END = CW'(2 * SLOTS + 2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_ERD   = 4'd4;
  localparam logic [3:0] S_EEMIT = 4'd5;
  localparam logic [3:0] S_DRD   = 4'd6;
  localparam logic [3:0] S_DRD2  = 4'd7;
  localparam logic [3:0] S_DEMIT = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [2:0]  op_r;
  logic [4:0]  slot_r;
  logic signed [KEY_BITS-1:0] key_r;
  logic [PAYLOAD_BITS-1:0]    pay_r;

  logic [SLOTS-1:0] live_r, live_nxt;
  logic [SLOTS-1:0] dirty_r, dirty_nxt;
  logic [CNTW-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CNTW-1:0]  used_r, used_nxt;
  logic [CNTW-1:0]  dcnt_r, dcnt_nxt;
  logic             rebuild_r, rebuild_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [SW-1:0]    pos_r, pos_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;

  // memories
  logic [EW-1:0] ent_mem [SLOTS];
  logic [SW-1:0] fstk_mem [SLOTS];
  logic [SW-1:0] dlist_mem [SLOTS];
  logic [SW-1:0] spos_mem [SLOTS];
  logic [EW-1:0] ent_rd_r;
  logic [SW-1:0] fstk_rd_r, dl_rd_r, spos_rd_r;

  logic          ent_we;
  logic [SW-1:0] ent_wa, ent_ra;
  logic [EW-1:0] ent_wd;
  logic          fstk_we, dl_we, spos_we;
  logic [SW-1:0] fstk_wa, dl_wa, spos_wa, spos_wd;
  logic [CNTW-1:0] fc_m1;

  logic signed [KEY_BITS-1:0] rd_key;
  logic [PAYLOAD_BITS-1:0]    rd_pay;

  // result register
  logic        res_load;
  logic [1:0]  res_status;
  logic [4:0]  res_slot, res_pos;
  logic signed [15:0] res_key;
  logic [63:0] res_pay;
  logic        res_full, res_ev, res_last;
  logic        out_free;

  // sorter chain
  cell_ctl_t                  cctl;
  logic                       ld_v_r;
  logic [SW-1:0]              ld_slot_r;
  logic                       c_occ   [SLOTS];
  logic signed [KEY_BITS-1:0] c_key   [SLOTS];
  logic [SW-1:0]              c_slot  [SLOTS];
  logic                       c_pv    [SLOTS];
  logic signed [KEY_BITS-1:0] c_pk    [SLOTS];
  logic [SW-1:0]              c_ps    [SLOTS];

  logic [SW-1:0] sidx;
  logic          slot_ok;
  logic          cell0_last;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign sidx     = SW'(slot_r);
  assign slot_ok  = (32'(slot_r) < SLOTS) && live_r[sidx];
  assign fc_m1    = free_cnt_r - CNTW'(1);
  assign rd_key   = ent_rd_r[EW-1:PAYLOAD_BITS];
  assign rd_pay   = ent_rd_r[PAYLOAD_BITS-1:0];

  generate
    if (SLOTS > 1) begin : g_last
      assign cell0_last = !c_occ[1];
    end else begin : g_last1
      assign cell0_last = 1'b1;
    end
  endgenerate

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      logic                       iv, no;
      logic signed [KEY_BITS-1:0] ik, nk;
      logic [SW-1:0]              is, ns;
      if (gi == 0) begin : g_head
        assign iv = ld_v_r;
        assign ik = rd_key;
        assign is = ld_slot_r;
      end else begin : g_body
        assign iv = c_pv[gi-1];
        assign ik = c_pk[gi-1];
        assign is = c_ps[gi-1];
      end
      if (gi == SLOTS - 1) begin : g_tail
        assign no = 1'b0;
        assign nk = '0;
        assign ns = '0;
      end else begin : g_mid
        assign no = c_occ[gi+1];
        assign nk = c_key[gi+1];
        assign ns = c_slot[gi+1];
      end
      dsr_cell #(.KEY_BITS(KEY_BITS), .SW(SW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(cctl),
        .ins_v(iv), .ins_key(ik), .ins_slot(is),
        .nb_occ(no), .nb_key(nk), .nb_slot(ns),
        .occ(c_occ[gi]), .key(c_key[gi]), .slot(c_slot[gi]),
        .pass_v(c_pv[gi]), .pass_key(c_pk[gi]), .pass_slot(c_ps[gi])
      );
    end
  endgenerate

  // read address held through an emit stall so the read data stays put
  always_comb begin
    unique case (state_r)
      S_LOAD:          ent_ra = cnt_r[SW-1:0];
      S_ERD, S_EEMIT:  ent_ra = c_slot[0];
      S_DRD2, S_DEMIT: ent_ra = dl_rd_r;
      default:         ent_ra = sidx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd_r <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (fstk_we) fstk_mem[fstk_wa] <= sidx;
    fstk_rd_r <= fstk_mem[fc_m1[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dl_we) dlist_mem[dl_wa] <= sidx;
    dl_rd_r <= dlist_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (spos_we) spos_mem[spos_wa] <= spos_wd;
    spos_rd_r <= spos_mem[dl_rd_r];
  end

  always_comb begin
    logic [SW-1:0] s;
    logic          nr;
    state_nxt    = state_r;
    live_nxt     = live_r;
    dirty_nxt    = dirty_r;
    free_cnt_nxt = free_cnt_r;
    used_nxt     = used_r;
    dcnt_nxt     = dcnt_r;
    rebuild_nxt  = rebuild_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    ent_we  = 1'b0;
    ent_wa  = sidx;
    ent_wd  = {key_r, pay_r};
    fstk_we = 1'b0;
    fstk_wa = free_cnt_r[SW-1:0];
    dl_we   = 1'b0;
    dl_wa   = dcnt_r[SW-1:0];
    spos_we = 1'b0;
    spos_wa = c_slot[0];
    spos_wd = pos_r;
    cctl    = '{clear: 1'b0, shift: 1'b0};
    res_load   = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    res_pos    = '0;
    res_key    = '0;
    res_pay    = '0;
    res_full   = 1'b0;
    res_ev     = 1'b0;
    res_last   = 1'b1;
    s  = '0;
    nr = rebuild_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (op_r == OP_FLUSH && rebuild_r) begin
          cctl.clear = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_LOAD;
        end else if (op_r == OP_FLUSH && dcnt_r != '0) begin
          idx_nxt   = '0;
          state_nxt = S_DRD;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
          unique case (op_r)
            OP_SUBMIT: begin
              if (free_cnt_r != '0) begin
                s = fstk_rd_r;
                free_cnt_nxt = fc_m1;
              end else if (32'(used_r) < SLOTS) begin
                s = used_r[SW-1:0];
                used_nxt = used_r + CNTW'(1);
              end else begin
                res_status = ST_FULL;
              end
              if (res_status == ST_OK) begin
                ent_we      = 1'b1;
                ent_wa      = s;
                live_nxt[s] = 1'b1;
                rebuild_nxt = 1'b1;
                res_slot    = 5'(s);
              end
            end
            OP_UPDATE: begin
              res_slot = slot_r;
              if (!slot_ok) begin
                res_status = ST_NOT_LIVE;
              end else begin
                nr          = rebuild_r || (rd_key != key_r);
                rebuild_nxt = nr;
                ent_we      = 1'b1;
                if (!nr && !dirty_r[sidx] && 32'(dcnt_r) < SLOTS) begin
                  dirty_nxt[sidx] = 1'b1;
                  dl_we           = 1'b1;
                  dcnt_nxt        = dcnt_r + CNTW'(1);
                end
              end
            end
            OP_RELEASE: begin
              res_slot = slot_r;
              if (!slot_ok || 32'(free_cnt_r) >= SLOTS) begin
                res_status = ST_NOT_LIVE;
              end else begin
                live_nxt[sidx]  = 1'b0;
                dirty_nxt[sidx] = 1'b0;
                fstk_we         = 1'b1;
                free_cnt_nxt    = free_cnt_r + CNTW'(1);
                rebuild_nxt     = 1'b1;
              end
            end
            OP_FLUSH: res_status = ST_NOTHING;
            default:  res_status = ST_OK;
          endcase
        end
      end
      S_LOAD: begin
        if (cnt_r != LOAD_END) begin
          cnt_nxt = cnt_r + CW'(1);
        end else if (c_occ[0]) begin
          pos_nxt   = '0;
          state_nxt = S_ERD;
        end else if (out_free) begin
          res_load    = 1'b1;
          res_full    = 1'b1;
          rebuild_nxt = 1'b0;
          dirty_nxt   = '0;
          dcnt_nxt    = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_ERD: state_nxt = S_EEMIT;
      S_EEMIT: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_slot   = 5'(c_slot[0]);
          res_pos    = 5'(pos_r);
          res_key    = 16'(c_key[0]);
          res_pay    = 64'(rd_pay);
          res_full   = 1'b1;
          res_ev     = 1'b1;
          res_last   = cell0_last;
          spos_we    = 1'b1;
          cctl.shift = 1'b1;
          pos_nxt    = pos_r + SW'(1);
          if (cell0_last) begin
            rebuild_nxt = 1'b0;
            dirty_nxt   = '0;
            dcnt_nxt    = '0;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      S_DRD:  state_nxt = S_DRD2;
      S_DRD2: state_nxt = S_DEMIT;
      S_DEMIT: begin
        if (out_free) begin
          res_load = 1'b1;
          res_slot = 5'(dl_rd_r);
          res_pos  = 5'(spos_rd_r);
          res_key  = 16'(rd_key);
          res_pay  = 64'(rd_pay);
          res_ev   = 1'b1;
          res_last = (CNTW'(idx_r) + CNTW'(1) == dcnt_r);
          idx_nxt  = idx_r + SW'(1);
          if (res_last) begin
            dirty_nxt = '0;
            dcnt_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      live_r     <= '0;
      dirty_r    <= '0;
      free_cnt_r <= '0;
      used_r     <= '0;
      dcnt_r     <= '0;
      rebuild_r  <= 1'b0;
      cnt_r      <= '0;
      pos_r      <= '0;
      idx_r      <= '0;
      ld_v_r     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      live_r     <= live_nxt;
      dirty_r    <= dirty_nxt;
      free_cnt_r <= free_cnt_nxt;
      used_r     <= used_nxt;
      dcnt_r     <= dcnt_nxt;
      rebuild_r  <= rebuild_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      idx_r      <= idx_nxt;
      ld_v_r     <= (state_r == S_LOAD) && (32'(cnt_r) < SLOTS) && live_r[cnt_r[SW-1:0]];
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ld_slot_r <= cnt_r[SW-1:0];
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= in_operation;
      slot_r <= in_slot_id;
      key_r  <= KEY_BITS'(in_depth_key);
      pay_r  <= PAYLOAD_BITS'(in_payload);
    end
    if (res_load) begin
      out_status       <= res_status;
      out_slot_out     <= res_slot;
      out_position     <= res_pos;
      out_key_out      <= res_key;
      out_payload_out  <= res_pay;
      out_full_refresh <= res_full;
      out_entry_valid  <= res_ev;
      out_last         <= res_last;
    end
  end

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(used_r) <= SLOTS) && (free_cnt_r <= used_r) && (32'(dcnt_r) <= SLOTS))
    else $error("slot counters out of range");

  a_emit_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EEMIT) |-> c_occ[0])
    else $error("emitting from an empty sorter chain");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !res_load)
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire
